// ----- sv/sctr_pkg.sv -----
package sctr_pkg;

    localparam int MAX_HARTS   = 8;
    localparam int HART_IDX_W  = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;
    localparam int ACT_W       = 4;
    localparam int ADDR_W      = 13;
    localparam int DATA_W      = 64;
    localparam int HALF_W      = 32;
    localparam int PEND_W      = 8;
    localparam int PEND_VIS    = (MAX_HARTS < PEND_W) ? MAX_HARTS : PEND_W;
    localparam int SOFT_HART_W = ADDR_W - 3;   // address bits 11:2
    localparam int CMP_HART_W  = ADDR_W - 4;   // address bits 11:3

    localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(1);

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } t_req_type;

    typedef struct packed {
        logic                  op_read;
        logic                  op_write;
        logic                  op_tick;
        logic                  err;
        logic                  cmp_win;
        logic                  hi_half;
        logic                  big;
        logic [HART_IDX_W-1:0] hart;
        logic [MAX_HARTS-1:0]  served_mask;
    } t_dec;

endpackage

// ----- sv/sctr_req_if.sv -----
interface sctr_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          req_type;
    logic [sctr_pkg::ADDR_W-1:0]         address;
    logic                                access_size_8;
    logic [sctr_pkg::DATA_W-1:0]         write_data;
    logic [sctr_pkg::DATA_W-1:0]         time_now;

    modport source (output valid, req_type, address, access_size_8, write_data, time_now,
                    input ready);
    modport sink (input valid, req_type, address, access_size_8, write_data, time_now,
                  output ready);
endinterface

// ----- sv/sctr_rsp_if.sv -----
interface sctr_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sctr_pkg::DATA_W-1:0]         read_data;
    logic                                access_error;
    logic [sctr_pkg::PEND_W-1:0]         soft_pending;
    logic [sctr_pkg::PEND_W-1:0]         timer_pending;

    modport source (output valid, read_data, access_error, soft_pending, timer_pending,
                    input ready);
    modport sink (input valid, read_data, access_error, soft_pending, timer_pending,
                  output ready);
endinterface

// ----- sv/sctr_cfg_if.sv -----
interface sctr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sctr_pkg::ACT_W-1:0]   active_harts;

    modport source (output valid, active_harts, input ready);
    modport sink (input valid, active_harts, output ready);
endinterface

// ----- sv/smode_clint_soft_and_timer_regs_unit.sv -----
// A request is held in the input register while it is decoded and applied; its result
// is captured in the result register. Throughput: one request per cycle unless the
// output stalls (result held, not taken); the input register and the result register
// each hand on their content whenever the stage ahead is free or being emptied.
// Reset (synchronous, active low): both stages empty, soft and timer bits zero,
// compares all ones, time zero, active_harts one.
module smode_clint_soft_and_timer_regs_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sctr_req_if.sink    i_req,
    sctr_cfg_if.sink    i_cfg,
    sctr_rsp_if.source  o_rsp
);

    logic                           r_s1_valid;
    logic [1:0]                     r_s1_req_type;
    logic [sctr_pkg::ADDR_W-1:0]    r_s1_address;
    logic                           r_s1_size_8;
    logic [sctr_pkg::DATA_W-1:0]    r_s1_write_data;
    logic [sctr_pkg::DATA_W-1:0]    r_s1_time_now;

    logic                           r_out_valid;
    logic [sctr_pkg::DATA_W-1:0]    r_out_read_data;
    logic                           r_out_error;
    logic [sctr_pkg::PEND_W-1:0]    r_out_soft;
    logic [sctr_pkg::PEND_W-1:0]    r_out_timer;

    logic [sctr_pkg::ACT_W-1:0]     r_active_harts;

    sctr_pkg::t_dec                 dec;
    logic                           advance;
    logic                           in_take;
    logic [sctr_pkg::DATA_W-1:0]    core_read_data;
    logic [sctr_pkg::PEND_W-1:0]    core_soft;
    logic [sctr_pkg::PEND_W-1:0]    core_timer;

    assign advance     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || advance;
    assign in_take     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_out_read_data;
    assign o_rsp.access_error  = r_out_error;
    assign o_rsp.soft_pending  = r_out_soft;
    assign o_rsp.timer_pending = r_out_timer;

    sctr_decode u_decode (
        .i_req_type      (r_s1_req_type),
        .i_address       (r_s1_address),
        .i_access_size_8 (r_s1_size_8),
        .i_active_harts  (r_active_harts),
        .o_dec           (dec)
    );

    sctr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_dec        (dec),
        .i_write_data (r_s1_write_data),
        .i_time_now   (r_s1_time_now),
        .o_read_data  (core_read_data),
        .o_soft_pend  (core_soft),
        .o_timer_pend (core_timer)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_active_harts <= sctr_pkg::ACT_RESET;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_active_harts <= i_cfg.active_harts;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_req_type   <= i_req.req_type;
            r_s1_address    <= i_req.address;
            r_s1_size_8     <= i_req.access_size_8;
            r_s1_write_data <= i_req.write_data;
            r_s1_time_now   <= i_req.time_now;
        end
        if (advance) begin
            r_out_read_data <= core_read_data;
            r_out_error     <= dec.err;
            r_out_soft      <= core_soft;
            r_out_timer     <= core_timer;
        end
    end

endmodule

// ----- sv/sctr_decode.sv -----
module sctr_decode (
    input  logic [1:0]                   i_req_type,
    input  logic [sctr_pkg::ADDR_W-1:0]  i_address,
    input  logic                         i_access_size_8,
    input  logic [sctr_pkg::ACT_W-1:0]   i_active_harts,
    output sctr_pkg::t_dec               o_dec
);

    logic [sctr_pkg::ACT_W-1:0]       served;
    logic [sctr_pkg::SOFT_HART_W-1:0] soft_hart;
    logic [sctr_pkg::CMP_HART_W-1:0]  cmp_hart;
    logic                             cmp_win;
    logic                             hart_bad;
    logic                             align_bad;

    always_comb begin
        if (32'(i_active_harts) > sctr_pkg::MAX_HARTS) begin
            served = sctr_pkg::ACT_W'(sctr_pkg::MAX_HARTS);
        end else begin
            served = i_active_harts;
        end

        // Bit 12 selects the compare window; the soft window sits below it.
        cmp_win   = i_address[sctr_pkg::ADDR_W-1];
        soft_hart = i_address[sctr_pkg::ADDR_W-2:2];
        cmp_hart  = i_address[sctr_pkg::ADDR_W-2:3];

        if (cmp_win) begin
            hart_bad  = 32'(cmp_hart) >= 32'(served);
            align_bad = (i_address[1:0] != 2'd0) || (i_address[2] && i_access_size_8);
        end else begin
            hart_bad  = 32'(soft_hart) >= 32'(served);
            align_bad = i_address[1:0] != 2'd0;
        end

        o_dec          = '0;
        o_dec.cmp_win  = cmp_win;
        o_dec.hi_half  = i_address[2];
        o_dec.big      = i_access_size_8;
        o_dec.hart     = cmp_win ? cmp_hart[sctr_pkg::HART_IDX_W-1:0]
                                 : soft_hart[sctr_pkg::HART_IDX_W-1:0];
        for (int h = 0; h < sctr_pkg::MAX_HARTS; h++) begin
            o_dec.served_mask[h] = 32'(h) < 32'(served);
        end

        case (sctr_pkg::t_req_type'(i_req_type))
            sctr_pkg::REQ_TICK: begin
                o_dec.op_tick = 1'b1;
            end
            sctr_pkg::REQ_READ: begin
                o_dec.err     = hart_bad || align_bad;
                o_dec.op_read = !(hart_bad || align_bad);
            end
            sctr_pkg::REQ_WRITE: begin
                o_dec.err      = hart_bad || align_bad;
                o_dec.op_write = !(hart_bad || align_bad);
            end
            default: begin
                o_dec.err = 1'b1;
            end
        endcase
    end

endmodule

// ----- sv/sctr_core.sv -----
module sctr_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  sctr_pkg::t_dec                i_dec,
    input  logic [sctr_pkg::DATA_W-1:0]   i_write_data,
    input  logic [sctr_pkg::DATA_W-1:0]   i_time_now,
    output logic [sctr_pkg::DATA_W-1:0]   o_read_data,
    output logic [sctr_pkg::PEND_W-1:0]   o_soft_pend,
    output logic [sctr_pkg::PEND_W-1:0]   o_timer_pend
);

    logic [sctr_pkg::MAX_HARTS-1:0]  r_soft;
    logic [sctr_pkg::MAX_HARTS-1:0]  n_soft;
    logic [sctr_pkg::MAX_HARTS-1:0]  r_timer;
    logic [sctr_pkg::MAX_HARTS-1:0]  n_timer;
    logic [sctr_pkg::DATA_W-1:0]     r_cmp [sctr_pkg::MAX_HARTS];
    logic [sctr_pkg::DATA_W-1:0]     n_cmp [sctr_pkg::MAX_HARTS];
    logic [sctr_pkg::DATA_W-1:0]     r_time;
    logic [sctr_pkg::DATA_W-1:0]     n_time;
    logic [sctr_pkg::DATA_W-1:0]     cur_cmp;
    logic [sctr_pkg::DATA_W-1:0]     new_cmp;

    always_comb begin
        n_soft  = r_soft;
        n_timer = r_timer;
        n_cmp   = r_cmp;
        n_time  = r_time;
        cur_cmp = r_cmp[i_dec.hart];

        if (i_dec.big) begin
            new_cmp = i_write_data;
        end else if (i_dec.hi_half) begin
            new_cmp = {i_write_data[sctr_pkg::HALF_W-1:0], cur_cmp[sctr_pkg::HALF_W-1:0]};
        end else begin
            new_cmp = {cur_cmp[sctr_pkg::DATA_W-1:sctr_pkg::HALF_W],
                       i_write_data[sctr_pkg::HALF_W-1:0]};
        end

        o_read_data = '0;
        if (i_dec.op_read) begin
            if (!i_dec.cmp_win) begin
                o_read_data = {{(sctr_pkg::DATA_W-1){1'b0}}, r_soft[i_dec.hart]};
            end else if (i_dec.hi_half) begin
                o_read_data = {{sctr_pkg::HALF_W{1'b0}},
                               cur_cmp[sctr_pkg::DATA_W-1:sctr_pkg::HALF_W]};
            end else if (i_dec.big) begin
                o_read_data = cur_cmp;
            end else begin
                o_read_data = {{sctr_pkg::HALF_W{1'b0}}, cur_cmp[sctr_pkg::HALF_W-1:0]};
            end
        end

        if (i_fire) begin
            if (i_dec.op_tick) begin
                // Every served hart compares against the new time in parallel.
                n_time = i_time_now;
                for (int h = 0; h < sctr_pkg::MAX_HARTS; h++) begin
                    if (i_dec.served_mask[h]) begin
                        n_timer[h] = i_time_now >= r_cmp[h];
                    end
                end
            end else if (i_dec.op_write) begin
                if (i_dec.cmp_win) begin
                    n_cmp[i_dec.hart]   = new_cmp;
                    n_timer[i_dec.hart] = r_time >= new_cmp;
                end else begin
                    n_soft[i_dec.hart] = i_write_data[0];
                end
            end
        end

        o_soft_pend  = '0;
        o_timer_pend = '0;
        for (int i = 0; i < sctr_pkg::PEND_VIS; i++) begin
            o_soft_pend[i]  = n_soft[i];
            o_timer_pend[i] = n_timer[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft  <= '0;
            r_timer <= '0;
            r_time  <= '0;
            for (int h = 0; h < sctr_pkg::MAX_HARTS; h++) begin
                r_cmp[h] <= '1;
            end
        end else begin
            r_soft  <= n_soft;
            r_timer <= n_timer;
            r_time  <= n_time;
            r_cmp   <= n_cmp;
        end
    end

endmodule

// ----- sv/sctr_checker.sv -----
module sctr_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_ready,
    input  logic                         i_cfg_ready,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [sctr_pkg::DATA_W-1:0]  i_out_read_data,
    input  logic                         i_out_error,
    input  logic [sctr_pkg::PEND_W-1:0]  i_out_soft,
    input  logic [sctr_pkg::PEND_W-1:0]  i_out_timer
);

    // Reset leaves both stages empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_req_ready)
        else $error("pipeline not empty after reset");

    // A flagged request never returns data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> i_out_read_data == '0)
        else $error("error result carries read data");

    // The register port never back-pressures.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

    // With the result stage empty, the input side must be free to take a request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_req_ready)
        else $error("input stalled while result stage empty");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_read_data)
            && $stable(i_out_error) && $stable(i_out_soft) && $stable(i_out_timer))
        else $error("stalled result changed");

endmodule

bind smode_clint_soft_and_timer_regs_unit sctr_checker u_sctr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_ready     (i_req.ready),
    .i_cfg_ready     (i_cfg.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_out_read_data (o_rsp.read_data),
    .i_out_error     (o_rsp.access_error),
    .i_out_soft      (o_rsp.soft_pending),
    .i_out_timer     (o_rsp.timer_pending)
);
